// ===== hdl/text_console_cursor_engine_macros.svh =====
// Assertion macros for the text console cursor engine.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// Condition that must hold at every edge out of reset.
`define TCCE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define TCCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcce_pkg.sv =====
// Package for the text console cursor engine: geometry, widths, codes.
// No dependencies.
package tcce_pkg;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned PAGES       = 2;
  localparam int unsigned SCREEN_CELLS = COLUMNS * ROWS;
  localparam int unsigned STORE_CELLS  = SCREEN_CELLS * PAGES;
  localparam int unsigned STORE_ROWS   = ROWS * PAGES;
  localparam int unsigned VIEW_LIMIT   = ROWS * (PAGES - 1);

  localparam int unsigned CH_W   = 8;
  localparam int unsigned CELL_W = 12;
  localparam int unsigned VIEW_W = 5;
  localparam int unsigned ROW_W  = $clog2(STORE_ROWS + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS);

  localparam logic [CH_W-1:0] ATTR_RESET = 8'h0f;
  localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0a;
  localparam logic [CH_W-1:0] CH_RETURN  = 8'h0d;
  localparam logic [CH_W-1:0] CH_BACKSP  = 8'h08;
  localparam logic [CH_W-1:0] CH_ESCAPE  = 8'h1b;

  typedef enum logic [1:0] {
    WK_NONE      = 2'd0,
    WK_CHAR_ATTR = 2'd1,
    WK_CHAR_ONLY = 2'd2
  } write_kind_e;

endpackage

// ===== hdl/text_console_cursor_engine.sv =====
// Text console cursor engine top level: cursor, scroll view and cell writes.
// Depends on tcce_pkg and text_console_cursor_engine_macros.svh.
//
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_ready_o   | ch_i
// out     | output    | out_valid_o / out_ready_i | write_kind_o .. cursor_pos_o
//
// One item per cycle unless a result stalls; its result is registered and shows in the cycle after accept.
// All cursor and scroll math is done in the accept cycle and lands in the
// result register; the column and row are kept beside the cursor.
// Reset: cursor 0, view 0, attribute 0x0f, escape clear, no result held.
// A stalled result stays put; a new item is taken in the cycle it drains.
`include "text_console_cursor_engine_macros.svh"

module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CH_W-1:0]   ch_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        write_kind_o,
  output logic [CELL_W-1:0] cell_index_o,
  output logic [CH_W-1:0]   cell_char_o,
  output logic [CH_W-1:0]   cell_attr_o,
  output logic              shift_up_o,
  output logic [VIEW_W-1:0] view_row_o,
  output logic              cursor_update_o,
  output logic [CELL_W-1:0] cursor_pos_o
);

  // state
  logic [CELL_W-1:0] cursor_q, cursor_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [VIEW_W-1:0] view_q, view_d;
  logic [VIEW_W-1:0] deep_q, deep_d;
  logic [CH_W-1:0]   attr_q, attr_d;
  logic              esc_q, esc_d;
  logic              out_valid_q, out_valid_d;

  // result
  write_kind_e       kind_q, kind_d;
  logic [CELL_W-1:0] idx_q, idx_d;
  logic [CH_W-1:0]   cch_q, cch_d;
  logic [CH_W-1:0]   cattr_q, cattr_d;
  logic              shift_q, shift_d;
  logic [VIEW_W-1:0] vrow_q;
  logic              upd_q, upd_d;
  logic [CELL_W-1:0] pos_q, pos_d;

  logic              accept;
  logic              tail;
  logic [CELL_W-1:0] cur_a;
  logic [ROW_W-1:0]  row_a;
  logic [ROW_W:0]    scroll_lim;
  logic [ROW_W:0]    deep_lim;
  logic [VIEW_W:0]   deep_inc;
  logic [CELL_W-1:0] view_base;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cur_a      = cursor_q;
    row_a      = row_q;
    col_d      = col_q;
    view_d     = view_q;
    attr_d     = attr_q;
    esc_d      = esc_q;
    tail       = 1'b1;
    kind_d     = WK_NONE;
    idx_d      = '0;
    cch_d      = '0;
    cattr_d    = '0;
    deep_inc   = {1'b0, deep_q} + (VIEW_W+1)'(1);
    scroll_lim = (ROW_W+1)'(ROWS) + (ROW_W+1)'(view_q);
    if (esc_q) begin
      attr_d = ch_i;
      esc_d  = 1'b0;
      tail   = 1'b0;
    end else begin
      case (ch_i)
        CH_NEWLINE: begin
          cur_a = cursor_q - CELL_W'(col_q) + CELL_W'(COLUMNS);
          row_a = row_q + ROW_W'(1);
          col_d = '0;
          if ({1'b0, row_a} >= scroll_lim && deep_q >= view_q) begin
            if (deep_inc > (VIEW_W+1)'(VIEW_LIMIT)) begin
              view_d = VIEW_W'(VIEW_LIMIT);
            end else begin
              view_d = deep_inc[VIEW_W-1:0];
            end
          end
        end
        CH_RETURN: begin
          cur_a = cursor_q - CELL_W'(col_q);
          col_d = '0;
        end
        CH_BACKSP: begin
          if (cursor_q != '0) begin
            cur_a  = cursor_q - CELL_W'(1);
            kind_d = WK_CHAR_ONLY;
            idx_d  = cur_a;
            if (col_q == '0) begin
              col_d = COL_W'(COLUMNS - 1);
              row_a = row_q - ROW_W'(1);
            end else begin
              col_d = col_q - COL_W'(1);
            end
          end
        end
        CH_ESCAPE: begin
          esc_d = 1'b1;
          tail  = 1'b0;
        end
        default: begin
          kind_d  = WK_CHAR_ATTR;
          idx_d   = cursor_q;
          cch_d   = ch_i;
          cattr_d = attr_q;
          cur_a   = cursor_q + CELL_W'(1);
          if (col_q == COL_W'(COLUMNS - 1)) begin
            col_d = '0;
            row_a = row_q + ROW_W'(1);
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      endcase
    end
  end

  // shift check, deepest row, display cursor
  always_comb begin
    cursor_d  = cur_a;
    row_d     = row_a;
    deep_d    = deep_q;
    shift_d   = 1'b0;
    upd_d     = 1'b0;
    pos_d     = '0;
    deep_lim  = (ROW_W+1)'(ROWS) + (ROW_W+1)'(deep_q);
    view_base = CELL_W'(view_d) * CELL_W'(COLUMNS);
    if (tail) begin
      if (cur_a >= CELL_W'(STORE_CELLS)) begin
        cursor_d = cur_a - CELL_W'(COLUMNS);
        row_d    = row_a - ROW_W'(1);
        shift_d  = 1'b1;
      end
      if ({1'b0, row_d} >= deep_lim) begin
        deep_d = deep_q + VIEW_W'(1);
      end
      if (row_d >= ROW_W'(view_d)) begin
        upd_d = 1'b1;
        pos_d = cursor_d - view_base;
      end
    end
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      view_q      <= '0;
      deep_q      <= '0;
      attr_q      <= ATTR_RESET;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        cursor_q <= cursor_d;
        row_q    <= row_d;
        col_q    <= col_d;
        view_q   <= view_d;
        deep_q   <= deep_d;
        attr_q   <= attr_d;
        esc_q    <= esc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      cch_q   <= cch_d;
      cattr_q <= cattr_d;
      shift_q <= shift_d;
      vrow_q  <= view_d;
      upd_q   <= upd_d;
      pos_q   <= pos_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_kind_o    = kind_q;
  assign cell_index_o    = idx_q;
  assign cell_char_o     = cch_q;
  assign cell_attr_o     = cattr_q;
  assign shift_up_o      = shift_q;
  assign view_row_o      = vrow_q;
  assign cursor_update_o = upd_q;
  assign cursor_pos_o    = pos_q;

  `TCCE_ASSERT(a_cursor_rowcol, 32'(cursor_q) == 32'(row_q) * COLUMNS + 32'(col_q),
               "cursor out of step with row/col")
  `TCCE_ASSERT(a_cursor_range, cursor_q < CELL_W'(STORE_CELLS) && col_q < COL_W'(COLUMNS),
               "cursor out of store")
  `TCCE_ASSERT(a_view_range, view_q <= VIEW_W'(VIEW_LIMIT) && deep_q <= VIEW_W'(ROWS),
               "view or deepest row out of range")
  `TCCE_ASSERT_IMP(a_write_index, out_valid_q && kind_q != WK_NONE,
                   idx_q < CELL_W'(STORE_CELLS), "cell write outside store")
  `TCCE_ASSERT_NXT(a_accept_result, accept, out_valid_q, "accepted item left no result")

endmodule

// ===== test/text_console_cursor_engine_tb.sv =====
`timescale 1ns / 1ps
// Testbench for text_console_cursor_engine: character stream in, cell writes and cursor out.
// Depends on tcce_pkg and the RTL; a scoreboard class predicts every result item.

module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  typedef struct {
    write_kind_e       kind;
    logic [CELL_W-1:0] cell_idx;
    logic [CH_W-1:0]   chr;
    logic [CH_W-1:0]   attr;
    logic              shift;
    logic [VIEW_W-1:0] view;
    logic              upd;
    logic [CELL_W-1:0] pos;
  } cell_result_t;

  class console_scoreboard;
    cell_result_t    expected_q[$];
    int unsigned     cursor;
    int unsigned     view_top;
    int unsigned     deepest;
    logic [CH_W-1:0] attr;
    bit              esc_armed;
    int              mismatches;

    function new();
      cursor     = 0;
      view_top   = 0;
      deepest    = 0;
      attr       = ATTR_RESET;
      esc_armed  = 1'b0;
      mismatches = 0;
    endfunction

    function void note_char(logic [CH_W-1:0] c);
      cell_result_t r;
      int unsigned  n;
      bit           tail;
      r.kind     = WK_NONE;
      r.cell_idx = '0;
      r.chr      = '0;
      r.attr     = '0;
      r.shift    = 1'b0;
      r.upd      = 1'b0;
      r.pos      = '0;
      tail       = 1'b1;
      if (esc_armed) begin
        attr      = c;
        esc_armed = 1'b0;
        tail      = 1'b0;
      end else if (c == CH_NEWLINE) begin
        cursor += COLUMNS - cursor % COLUMNS;
        if (cursor >= SCREEN_CELLS + view_top * COLUMNS) begin
          n = (deepest >= view_top) ? deepest - view_top + 1 : 0;
          if (view_top >= VIEW_LIMIT) n = 0;
          else if (n > VIEW_LIMIT - view_top) n = VIEW_LIMIT - view_top;
          view_top += n;
        end
      end else if (c == CH_RETURN) begin
        cursor -= cursor % COLUMNS;
      end else if (c == CH_BACKSP) begin
        if (cursor != 0) begin
          cursor--;
          r.kind     = WK_CHAR_ONLY;
          r.cell_idx = CELL_W'(cursor);
        end
      end else if (c == CH_ESCAPE) begin
        esc_armed = 1'b1;
        tail      = 1'b0;
      end else begin
        r.kind     = WK_CHAR_ATTR;
        r.cell_idx = CELL_W'(cursor);
        r.chr      = c;
        r.attr     = attr;
        cursor++;
      end
      if (tail) begin
        if (cursor >= STORE_CELLS) begin
          cursor -= COLUMNS;
          r.shift = 1'b1;
        end
        if (cursor >= SCREEN_CELLS + deepest * COLUMNS) deepest++;
        if (cursor >= view_top * COLUMNS) begin
          r.upd = 1'b1;
          r.pos = CELL_W'(cursor - view_top * COLUMNS);
        end
      end
      r.view = VIEW_W'(view_top);
      expected_q.push_back(r);
    endfunction

    function string fmt(cell_result_t r);
      return $sformatf("kind=%0d idx=%0d ch=%02h attr=%02h shift=%0d view=%0d upd=%0d pos=%0d",
                       r.kind, r.cell_idx, r.chr, r.attr, r.shift, r.view, r.upd, r.pos);
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %s", fmt(got));
        return;
      end
      e = expected_q.pop_front();
      if (got.kind !== e.kind || got.cell_idx !== e.cell_idx || got.chr !== e.chr ||
          got.attr !== e.attr || got.shift !== e.shift || got.view !== e.view ||
          got.upd !== e.upd || got.pos !== e.pos) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", fmt(e));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [CH_W-1:0]   ch_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        write_kind_o;
  logic [CELL_W-1:0] cell_index_o;
  logic [CH_W-1:0]   cell_char_o;
  logic [CH_W-1:0]   cell_attr_o;
  logic              shift_up_o;
  logic [VIEW_W-1:0] view_row_o;
  logic              cursor_update_o;
  logic [CELL_W-1:0] cursor_pos_o;

  console_scoreboard sb;
  cell_result_t      mon_result;
  int                idle_pct;
  int                stall_pct;

  logic [CH_W-1:0] opening_chars [24] = '{
    8'h48, 8'h00, 8'hff, CH_BACKSP, CH_RETURN, CH_BACKSP, CH_ESCAPE, 8'hff,
    8'h78, CH_ESCAPE, CH_ESCAPE, 8'h7f, CH_ESCAPE, CH_NEWLINE, 8'h61, CH_ESCAPE,
    8'h00, 8'h62, CH_NEWLINE, CH_BACKSP, CH_RETURN, CH_ESCAPE, 8'h0f, CH_NEWLINE
  };

  text_console_cursor_engine DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ch_i           (ch_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_kind_o   (write_kind_o),
    .cell_index_o   (cell_index_o),
    .cell_char_o    (cell_char_o),
    .cell_attr_o    (cell_attr_o),
    .shift_up_o     (shift_up_o),
    .view_row_o     (view_row_o),
    .cursor_update_o(cursor_update_o),
    .cursor_pos_o   (cursor_pos_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_char(ch_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      mon_result.kind     = write_kind_e'(write_kind_o);
      mon_result.cell_idx = cell_index_o;
      mon_result.chr      = cell_char_o;
      mon_result.attr     = cell_attr_o;
      mon_result.shift    = shift_up_o;
      mon_result.view     = view_row_o;
      mon_result.upd      = cursor_update_o;
      mon_result.pos      = cursor_pos_o;
      sb.check_result(mon_result);
    end
  end

  // Entered and left at a falling edge.
  task automatic send_char(logic [CH_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly text and line control, with escape pairs and raw bytes mixed in.
  task automatic run_random(int count);
    int sent;
    int roll;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_char(CH_W'($urandom_range(8'h7e, 8'h20)));
      end else if (roll < 60) begin
        send_char(CH_NEWLINE);
      end else if (roll < 66) begin
        send_char(CH_RETURN);
      end else if (roll < 75) begin
        send_char(CH_BACKSP);
      end else if (roll < 82) begin
        send_char(CH_ESCAPE);
        send_char(CH_W'($urandom_range(255)));
        sent++;
      end else begin
        send_char(CH_W'($urandom_range(255)));
      end
      sent++;
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ch_i        = '0;
    out_ready_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening_chars[i]) send_char(opening_chars[i]);
    run_random(312);
    idle_pct = 88;
    run_random(312);
    idle_pct  = 0;
    stall_pct = 88;
    run_random(312);
    idle_pct  = 9;
    stall_pct = 9;
    run_random(312);
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
